// File: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and constants for the bitmap page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int MaxPages   = 65536;
  localparam int PageShift  = 12;                    // 4 KiB pages
  localparam int WordBits   = 64;
  localparam int BitIdxW    = $clog2(WordBits);      // bit within a map word
  localparam int PageIdxW   = $clog2(MaxPages);      // page number
  localparam int CountW     = PageIdxW + 1;          // page and free counts
  localparam int MapWords   = MaxPages / WordBits;
  localparam int WordAw     = $clog2(MapWords);
  localparam int AddrW      = 48;
  localparam int PageAddrW  = PageIdxW + PageShift;
  localparam int MapBytesW  = 14;

  localparam logic [MapBytesW-1:0] MapBytesReset = 14'd8192;

  // command codes
  localparam logic [1:0] CmdAlloc = 2'd0;
  localparam logic [1:0] CmdFree  = 2'd1;
  localparam logic [1:0] CmdInit  = 2'd2;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AddrW-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic [PageAddrW-1:0] page_address;
    logic [CountW-1:0]    free_count;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit physical page allocator over a one-bit-per-page map in block ram
// ----------------------------------------------------------------------------
// init clears one map word per cycle, alloc reads one map word per cycle and
//   writes a found word back, free reads, checks and writes back one word; every
//   result then passes through the output register. one item is worked on at a time.
// reset: control state and counts cleared, map_bytes back to 8192; the map ram
//   itself is not swept after reset, init clears the words it will manage.
`default_nettype none

module bitmap_page_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration: map size in bytes
  input  wire                          cfg_we_i,
  input  wire [bpa_pkg::MapBytesW-1:0] cfg_wdata_i,
  // command channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire bpa_pkg::in_item_t       in_item_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output bpa_pkg::out_item_t           out_item_o
);

  import bpa_pkg::*;

  // one-hot sequencer
  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StInit = 6'b000010,  // clear sweep over the managed words
    StScan = 6'b000100,  // first-fit search, one word read per cycle
    StFrd  = 6'b001000,  // free: read the word holding the page
    StFchk = 6'b010000,  // free: check the bit and write back
    StDone = 6'b100000   // result waits for the output register
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic [MapBytesW-1:0] map_bytes_q;

  // allocator state
  logic [CountW-1:0]   page_total_q, page_total_d;
  logic [CountW-1:0]   free_total_q, free_total_d;
  logic                map_ready_q, map_ready_d;

  // sweep / scan bookkeeping
  logic [WordAw-1:0]   rd_q, rd_d;         // next word to read or clear
  logic                rd_end_q, rd_end_d; // last word already issued
  logic                chk_vld_q, chk_vld_d;
  logic [WordAw-1:0]   chk_w_q, chk_w_d;   // word whose data sits in rdata_q
  logic [PageIdxW-1:0] pg_q, pg_d;         // page to free

  // pending result
  logic                 res_status_q, res_status_d;
  logic [PageAddrW-1:0] res_addr_q, res_addr_d;

  // output register
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;

  // map ram, registered read
  logic [WordBits-1:0] map_mem [MapWords];
  logic [WordBits-1:0] rdata_q;
  logic [WordAw-1:0]   raddr;
  logic                mem_we;
  logic [WordAw-1:0]   waddr;
  logic [WordBits-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[waddr] <= wdata;
    end
    rdata_q <= map_mem[raddr];
  end

  // last managed word: (pages - 1) / 64
  logic [PageIdxW-1:0] tot_m1;
  logic [WordAw-1:0]   last_w;
  assign tot_m1 = PageIdxW'(page_total_q - CountW'(1));
  assign last_w = tot_m1[PageIdxW-1:BitIdxW];

  // free bits of the word under check, tail of a partial last word masked off
  logic [WordBits-1:0] avail;
  logic [WordBits-1:0] tail_mask;
  logic [BitIdxW-1:0]  hit_bit;
  logic                hit;

  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      tail_mask[b] = (BitIdxW'(b) < page_total_q[BitIdxW-1:0]);
    end
    if (chk_w_q == last_w && page_total_q[BitIdxW-1:0] != '0) begin
      avail = ~rdata_q & tail_mask;
    end else begin
      avail = ~rdata_q;
    end
    hit     = (avail != '0);
    hit_bit = '0;
    // lowest set bit wins
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit_bit = BitIdxW'(b);
      end
    end
  end

  // free address checks: nonzero, page aligned, inside the latched count
  logic [AddrW-PageShift-1:0] in_page;
  logic                       free_ok;
  assign in_page = in_item_i.address[AddrW-1:PageShift];
  assign free_ok = (in_item_i.address != '0)
                && (in_item_i.address[PageShift-1:0] == '0)
                && (in_page < (AddrW-PageShift)'(page_total_q));

  // init page count, saturated at the map capacity
  logic [CountW-1:0] init_pages;
  assign init_pages = ({map_bytes_q, 3'b000} > CountW'(MaxPages)) ? CountW'(MaxPages)
                                                                 : {map_bytes_q, 3'b000};

  logic in_acc;
  logic out_free;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    page_total_d = page_total_q;
    free_total_d = free_total_q;
    map_ready_d  = map_ready_q;
    rd_d         = rd_q;
    rd_end_d     = rd_end_q;
    chk_vld_d    = 1'b0;
    chk_w_d      = chk_w_q;
    pg_d         = pg_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_d        = out_q;
    raddr        = rd_q;
    mem_we       = 1'b0;
    waddr        = rd_q;
    wdata        = '0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_status_d = StatusFail;
          res_addr_d   = '0;
          rd_d         = '0;
          rd_end_d     = 1'b0;
          state_d      = StDone;
          case (in_item_i.cmd)
            CmdInit: begin
              if (map_bytes_q != '0) begin
                page_total_d = init_pages;
                state_d      = StInit;
              end
            end
            CmdAlloc: begin
              // free count is exact, so zero means no page to find
              if (map_ready_q && free_total_q != '0) begin
                state_d = StScan;
              end
            end
            CmdFree: begin
              if (free_ok) begin
                pg_d    = in_page[PageIdxW-1:0];
                state_d = StFrd;
              end
            end
            default: begin
              state_d = StDone;
            end
          endcase
        end
      end

      StInit: begin
        // clear one word per cycle, page 0 stays reserved
        mem_we = 1'b1;
        waddr  = rd_q;
        wdata  = (rd_q == '0) ? WordBits'(1) : '0;
        if (rd_q == last_w) begin
          free_total_d = page_total_q - CountW'(1);
          map_ready_d  = 1'b1;
          res_status_d = StatusOk;
          state_d      = StDone;
        end else begin
          rd_d = rd_q + WordAw'(1);
        end
      end

      StScan: begin
        // issue the next read while the previous word is checked
        raddr = rd_q;
        if (!rd_end_q) begin
          chk_vld_d = 1'b1;
          chk_w_d   = rd_q;
          if (rd_q == last_w) begin
            rd_end_d = 1'b1;
          end else begin
            rd_d = rd_q + WordAw'(1);
          end
        end
        if (chk_vld_q && hit) begin
          mem_we       = 1'b1;
          waddr        = chk_w_q;
          wdata        = rdata_q | (WordBits'(1) << hit_bit);
          free_total_d = free_total_q - CountW'(1);
          res_status_d = StatusOk;
          res_addr_d   = {chk_w_q, hit_bit, {PageShift{1'b0}}};
          chk_vld_d    = 1'b0;
          state_d      = StDone;
        end else if (!chk_vld_q && rd_end_q) begin
          state_d = StDone;
        end
      end

      StFrd: begin
        raddr   = pg_q[PageIdxW-1:BitIdxW];
        state_d = StFchk;
      end

      StFchk: begin
        if (rdata_q[pg_q[BitIdxW-1:0]]) begin
          mem_we       = 1'b1;
          waddr        = pg_q[PageIdxW-1:BitIdxW];
          wdata        = rdata_q & ~(WordBits'(1) << pg_q[BitIdxW-1:0]);
          free_total_d = free_total_q + CountW'(1);
          res_status_d = StatusOk;
        end
        state_d = StDone;
      end

      StDone: begin
        // counts are already updated here
        if (out_free) begin
          out_vld_d          = 1'b1;
          out_d.status       = res_status_q;
          out_d.page_address = res_addr_q;
          out_d.free_count   = free_total_q;
          state_d            = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      map_bytes_q  <= MapBytesReset;
      page_total_q <= '0;
      free_total_q <= '0;
      map_ready_q  <= 1'b0;
      rd_end_q     <= 1'b0;
      chk_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        map_bytes_q <= cfg_wdata_i;
      end
      page_total_q <= page_total_d;
      free_total_q <= free_total_d;
      map_ready_q  <= map_ready_d;
      rd_end_q     <= rd_end_d;
      chk_vld_q    <= chk_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_q         <= rd_d;
    chk_w_q      <= chk_w_d;
    pg_q         <= pg_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// self-checking bench for the first-fit bitmap page allocator: an in-bench
// model of the page map predicts every response, a monitor compares each
// response beat field by field, and directed tests of unready and tiny maps
// are followed by random traffic over many map sizes with idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  // the one command code the block does not define
  localparam logic [1:0] CmdUnused = 2'd3;

  // generous bound: every beat paying a full map scan plus both idle bursts
  localparam longint unsigned RunLimitNs = 64'd30_000_000;
  // longest single command (full scan of 1024 words) with output register
  localparam int unsigned DrainCycles = 1100;

  // --------------------------------------------------------------------------
  // clock, reset and block wiring
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [MapBytesW-1:0] cfg_wdata = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  in_item_t             cmd_beat  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  out_item_t            rsp_beat;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_page_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .in_item_i   (cmd_beat),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .out_item_o  (rsp_beat)
  );

  // --------------------------------------------------------------------------
  // page map model: its own copy of the map, counts and map size register
  // --------------------------------------------------------------------------
  bit [WordBits-1:0]    used_map [MapWords];
  int unsigned          pages_latched = 0;
  int unsigned          free_pages    = 0;
  bit                   map_ready     = 1'b0;
  logic [MapBytesW-1:0] map_bytes_reg = MapBytesReset;

  // bookkeeping for the summary and the verdict
  out_item_t   responses_due [$];
  int unsigned mismatches      = 0;
  int unsigned responses_seen  = 0;
  int unsigned commands_sent   = 0;
  int unsigned pages_granted   = 0;
  int unsigned pages_released  = 0;
  int unsigned commands_refused = 0;
  int unsigned sizes_tried     = 0;
  bit          calm            = 1'b0;   // no idling on either side when set

  // apply one command to the model and return the response it must produce
  function automatic out_item_t apply_page_command(in_item_t item);
    out_item_t   rsp;
    int unsigned want_pages;
    int unsigned found;
    int unsigned w;
    int unsigned b;
    logic [AddrW-PageShift-1:0] page;
    bit          hit;
    rsp.status       = StatusFail;
    rsp.page_address = '0;
    hit              = 1'b0;
    found            = 0;
    case (item.cmd)
      CmdInit: begin
        // a zero map size refuses and keeps whatever map was there
        if (map_bytes_reg != '0) begin
          want_pages    = int'(map_bytes_reg) * 8;
          pages_latched = (want_pages > MaxPages) ? MaxPages : want_pages;
          foreach (used_map[i]) used_map[i] = '0;
          used_map[0][0] = 1'b1;          // page 0 is never handed out
          free_pages     = pages_latched - 1;
          map_ready      = 1'b1;
          rsp.status     = StatusOk;
        end
      end
      CmdAlloc: begin
        // first fit: lowest clear bit below the latched page count
        if (map_ready) begin
          for (w = 0; w < MapWords && !hit && w * WordBits < pages_latched; w++) begin
            if (!(&used_map[w])) begin
              for (b = 0; b < WordBits && !hit; b++) begin
                if (w * WordBits + b < pages_latched && !used_map[w][b]) begin
                  hit   = 1'b1;
                  found = w * WordBits + b;
                end
              end
            end
          end
        end
        if (hit) begin
          used_map[found / WordBits][found % WordBits] = 1'b1;
          free_pages--;
          rsp.page_address = PageAddrW'(found) << PageShift;
          rsp.status       = StatusOk;
          pages_granted++;
        end
      end
      CmdFree: begin
        // zero, unaligned, out of range and already free addresses all refuse
        page = item.address[AddrW-1:PageShift];
        if (item.address != '0 && item.address[PageShift-1:0] == '0 &&
            page < pages_latched && used_map[page[15:6]][page[5:0]]) begin
          used_map[page[15:6]][page[5:0]] = 1'b0;
          free_pages++;
          rsp.status = StatusOk;
          pages_released++;
        end
      end
      default: ;   // unused code changes nothing
    endcase
    if (rsp.status == StatusFail) commands_refused++;
    rsp.free_count = free_pages[CountW-1:0];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // response side: random stall bursts and the response monitor
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (calm) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 10);
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // every accepted response beat against the oldest outstanding prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (responses_due.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing outstanding: %p", rsp_beat));
      end else begin
        want = responses_due.pop_front();
        responses_seen++;
        if (rsp_beat.status !== want.status)
          report_mismatch($sformatf("status expected %0d got %0d",
                                    want.status, rsp_beat.status));
        if (rsp_beat.page_address !== want.page_address)
          report_mismatch($sformatf("page_address expected 0x%07h got 0x%07h",
                                    want.page_address, rsp_beat.page_address));
        if (rsp_beat.free_count !== want.free_count)
          report_mismatch($sformatf("free_count expected %0d got %0d",
                                    want.free_count, rsp_beat.free_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------

  // one command beat, sometimes with a random idle burst ahead of it
  task automatic send_command(input logic [1:0] cmd, input logic [AddrW-1:0] address);
    in_item_t item;
    item.cmd     = cmd;
    item.address = address;
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat  <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    // accepted at this edge: predict in acceptance order
    responses_due.push_back(apply_page_command(item));
    commands_sent++;
  endtask

  // stop sending and wait until every prediction has been matched
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  // map size register, only written with the block idle
  task automatic set_map_bytes(input logic [MapBytesW-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    map_bytes_reg  = value;
    sizes_tried++;
  endtask

  // random command, mostly well formed: allocs and frees of pages in use
  function automatic in_item_t next_random_command();
    in_item_t    item;
    logic [63:0] raw;
    int unsigned roll;
    int unsigned span;
    int unsigned start;
    int unsigned p;
    bit          hit;
    raw          = {$urandom(), $urandom()};
    item.cmd     = CmdAlloc;
    item.address = raw[AddrW-1:0];   // ignored by alloc, but toggles every bit
    roll         = $urandom_range(0, 99);
    span         = (pages_latched > 1) ? pages_latched - 1 : 1;
    hit          = 1'b0;
    p            = 1;
    if (roll < 45) begin
      item.cmd = CmdAlloc;
    end else if (roll < 80) begin
      // free a page in use, searched from a random start
      item.cmd = CmdFree;
      start    = $urandom_range(1, span);
      for (int k = 0; k < span && !hit; k++) begin
        p = 1 + (start - 1 + k) % span;
        if (p < pages_latched && used_map[p / WordBits][p % WordBits]) hit = 1'b1;
      end
      if (hit) item.address = AddrW'(p) << PageShift;
    end else if (roll < 84) begin
      item.cmd = CmdInit;
    end else if (roll < 87) begin
      item.cmd = CmdUnused;
    end else begin
      // broken frees
      item.cmd = CmdFree;
      case ($urandom_range(0, 4))
        0: item.address = '0;
        1: item.address = (AddrW'($urandom_range(0, span)) << PageShift) |
                          AddrW'($urandom_range(1, (1 << PageShift) - 1));
        2: item.address = AddrW'(pages_latched + $urandom_range(0, 4095)) << PageShift;
        3: item.address = AddrW'($urandom_range(1, span)) << PageShift;
        default: item.address = {raw[AddrW-1:PageShift], {PageShift{1'b0}}};
      endcase
    end
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // commands before any init, init at the reset size, refused zero-size init
  task automatic test_unready_map();
    send_command(CmdAlloc, {AddrW{1'b1}});
    send_command(CmdFree, AddrW'(1) << PageShift);
    send_command(CmdUnused, {AddrW{1'b1}});
    send_command(CmdInit, '0);                 // reset size: full 65536 pages
    set_map_bytes('0);
    send_command(CmdInit, '0);                 // refused, old map stays
    send_command(CmdAlloc, '0);                // still hands out page 1
  endtask

  // eight-page map: fill it, every kind of bad free, reuse, re-init
  task automatic test_tiny_map();
    set_map_bytes(MapBytesW'(1));
    send_command(CmdInit, '0);
    repeat (8) send_command(CmdAlloc, '0);     // seven granted, then full
    send_command(CmdFree, '0);
    send_command(CmdFree, AddrW'(4097));
    send_command(CmdFree, {AddrW{1'b1}});
    send_command(CmdFree, {{(AddrW-PageShift){1'b1}}, {PageShift{1'b0}}});
    send_command(CmdFree, AddrW'(8) << PageShift);   // just past the map
    send_command(CmdFree, AddrW'(3) << PageShift);
    send_command(CmdFree, AddrW'(3) << PageShift);   // already free
    send_command(CmdAlloc, '0);                      // first fit gives page 3 back
    send_command(CmdInit, '0);
  endtask

  // random traffic on one map size, opened by an init
  task automatic test_random_traffic(input logic [MapBytesW-1:0] size, input int unsigned beats);
    in_item_t item;
    set_map_bytes(size);
    send_command(CmdInit, '0);
    repeat (beats) begin
      item = next_random_command();
      send_command(item.cmd, item.address);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unready_map();
    test_tiny_map();

    // small maps dominate; oversized and full-size maps only a few times
    test_random_traffic(MapBytesW'(16383), 44);   // saturates to the page limit
    test_random_traffic(MapBytesW'(2), 44);
    test_random_traffic(MapBytesW'(1), 44);
    test_random_traffic(MapBytesW'(5), 44);
    test_random_traffic(MapBytesW'(64), 44);
    test_random_traffic(MapBytesW'(0), 44);       // init refused, map carries over
    test_random_traffic(MapBytesW'(3), 44);
    test_random_traffic(MapBytesW'(200), 44);
    test_random_traffic(MapBytesW'(8192), 44);
    test_random_traffic(MapBytesW'(9), 44);
    // closing stretch without idling
    calm = 1'b1;
    test_random_traffic(MapBytesW'(1), 44);
    test_random_traffic(MapBytesW'(4), 44);

    settle();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d commands over %0d map size settings, %0d responses checked",
             commands_sent, sizes_tried, responses_seen);
    $display("granted %0d allocations and %0d frees, %0d commands refused, %0d mismatches",
             pages_granted, pages_released, commands_refused, mismatches);
    if (mismatches == 0 && responses_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RunLimitNs);
    $display("timeout with %0d responses outstanding", responses_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
